// ===== design/plvl_pkg.sv =====
// ----------------------------------------------------------------------------
// plvl_pkg
// Shared widths and stage types for the van Leer reconstruction pipeline.
// ----------------------------------------------------------------------------
package plvl_pkg;

    localparam int DATA_W = 32;
    localparam int DIFF_W = DATA_W + 1;
    localparam int MAG_W  = DATA_W;
    localparam int SUM_W  = MAG_W + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int QUO_W  = MAG_W;

    typedef struct packed {
        logic valid;
        logic neg;
        logic zero;
    } plvl_ctl_t;

    typedef struct packed {
        logic [SUM_W-1:0]         rem;
        logic [QUO_W-1:0]         lo;
        logic [SUM_W-1:0]         dsr;
        logic signed [DATA_W-1:0] centre;
    } plvl_div_t;

endpackage

// ===== design/plvl_slope_prep.sv =====
// ----------------------------------------------------------------------------
// plvl_slope_prep
// Differences, limiter sign test, magnitudes, sum and product; three stages.
// ----------------------------------------------------------------------------
module plvl_slope_prep
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    input  logic signed [plvl_pkg::DATA_W-1:0]       prev_value,
    input  logic signed [plvl_pkg::DATA_W-1:0]       centre_value,
    input  logic signed [plvl_pkg::DATA_W-1:0]       next_value,
    output plvl_pkg::plvl_ctl_t                      ctl_out,
    output plvl_pkg::plvl_div_t                      dat_out
);

    // stage A: differences
    logic                                 va_reg;
    logic signed [plvl_pkg::DIFF_W-1:0]   a_reg, a_next;
    logic signed [plvl_pkg::DIFF_W-1:0]   b_reg, b_next;
    logic signed [plvl_pkg::DATA_W-1:0]   ca_reg;

    // stage B: magnitudes and sum
    plvl_pkg::plvl_ctl_t                  ctlb_reg, ctlb_next;
    logic [plvl_pkg::MAG_W-1:0]           ma_reg, ma_next;
    logic [plvl_pkg::MAG_W-1:0]           mb_reg, mb_next;
    logic [plvl_pkg::SUM_W-1:0]           sum_reg, sum_next;
    logic signed [plvl_pkg::DATA_W-1:0]   cb_reg;

    // stage C: product
    plvl_pkg::plvl_ctl_t                  ctlc_reg;
    plvl_pkg::plvl_div_t                  datc_reg, datc_next;

    logic [plvl_pkg::DIFF_W-1:0]          na, nb;
    logic [plvl_pkg::PROD_W-1:0]          prod;

    always_comb
    begin
        a_next = $signed({centre_value[plvl_pkg::DATA_W-1], centre_value})
               - $signed({prev_value[plvl_pkg::DATA_W-1], prev_value});
        b_next = $signed({next_value[plvl_pkg::DATA_W-1], next_value})
               - $signed({centre_value[plvl_pkg::DATA_W-1], centre_value});
    end

    always_comb
    begin
        na              = ~a_reg + 1'b1;
        nb              = ~b_reg + 1'b1;
        ctlb_next.valid = va_reg;
        ctlb_next.neg   = a_reg[plvl_pkg::DIFF_W-1];
        ctlb_next.zero  = (a_reg == '0) || (b_reg == '0)
                        || (a_reg[plvl_pkg::DIFF_W-1] != b_reg[plvl_pkg::DIFF_W-1]);
        ma_next         = a_reg[plvl_pkg::DIFF_W-1] ? na[plvl_pkg::MAG_W-1:0]
                                                    : a_reg[plvl_pkg::MAG_W-1:0];
        mb_next         = a_reg[plvl_pkg::DIFF_W-1] ? nb[plvl_pkg::MAG_W-1:0]
                                                    : b_reg[plvl_pkg::MAG_W-1:0];
        sum_next        = {1'b0, ma_next} + {1'b0, mb_next};
    end

    // quotient fits in MAG_W bits, so the upper product half is already below the divisor
    always_comb
    begin
        prod             = {{plvl_pkg::MAG_W{1'b0}}, ma_reg}
                         * {{plvl_pkg::MAG_W{1'b0}}, mb_reg};
        datc_next.rem    = {1'b0, prod[plvl_pkg::PROD_W-1:plvl_pkg::MAG_W]};
        datc_next.lo     = prod[plvl_pkg::MAG_W-1:0];
        datc_next.dsr    = sum_reg;
        datc_next.centre = cb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            ctlb_reg <= '0;
            ctlc_reg <= '0;
        end
        else
        begin
            va_reg   <= in_valid;
            ctlb_reg <= ctlb_next;
            ctlc_reg <= ctlb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        ca_reg   <= centre_value;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        sum_reg  <= sum_next;
        cb_reg   <= ca_reg;
        datc_reg <= datc_next;
    end

    assign ctl_out = ctlc_reg;
    assign dat_out = datc_reg;

endmodule

// ===== design/plvl_div_stage.sv =====
// ----------------------------------------------------------------------------
// plvl_div_stage
// One restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module plvl_div_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  plvl_pkg::plvl_ctl_t  ctl_in,
    input  plvl_pkg::plvl_div_t  dat_in,
    output plvl_pkg::plvl_ctl_t  ctl_out,
    output plvl_pkg::plvl_div_t  dat_out
);

    plvl_pkg::plvl_ctl_t          ctl_reg;
    plvl_pkg::plvl_div_t          dat_reg, dat_next;

    logic [plvl_pkg::SUM_W:0]     shifted;
    logic [plvl_pkg::SUM_W+1:0]   trial;
    logic                         qbit;

    always_comb
    begin
        shifted         = {dat_in.rem, dat_in.lo[plvl_pkg::QUO_W-1]};
        trial           = {1'b0, shifted} - {2'b00, dat_in.dsr};
        qbit            = ~trial[plvl_pkg::SUM_W+1];
        dat_next        = dat_in;
        dat_next.rem    = qbit ? trial[plvl_pkg::SUM_W-1:0] : shifted[plvl_pkg::SUM_W-1:0];
        dat_next.lo     = {dat_in.lo[plvl_pkg::QUO_W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        dat_reg <= dat_next;
    end

    assign ctl_out = ctl_reg;
    assign dat_out = dat_reg;

endmodule

// ===== design/plvl_face.sv =====
// ----------------------------------------------------------------------------
// plvl_face
// Applies the signed half slope to the centre value; registered outputs.
// ----------------------------------------------------------------------------
module plvl_face
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  plvl_pkg::plvl_ctl_t                 ctl_in,
    input  plvl_pkg::plvl_div_t                 dat_in,
    output logic                                done,
    output logic signed [plvl_pkg::DATA_W-1:0]  upper_face,
    output logic signed [plvl_pkg::DATA_W-1:0]  lower_face
);

    logic                                 done_reg;
    logic signed [plvl_pkg::DATA_W-1:0]   upper_reg, upper_next;
    logic signed [plvl_pkg::DATA_W-1:0]   lower_reg, lower_next;

    logic [plvl_pkg::DIFF_W-1:0]          mag;
    logic [plvl_pkg::DIFF_W-1:0]          half;
    logic [plvl_pkg::DIFF_W-1:0]          cext;
    logic [plvl_pkg::DIFF_W-1:0]          up_sum;
    logic [plvl_pkg::DIFF_W-1:0]          lo_sum;

    always_comb
    begin
        mag        = {1'b0, dat_in.lo};
        if (ctl_in.zero)
            half = '0;
        else if (ctl_in.neg)
            half = ~mag + 1'b1;
        else
            half = mag;
        cext       = {dat_in.centre[plvl_pkg::DATA_W-1], dat_in.centre};
        up_sum     = cext + half;
        lo_sum     = cext - half;
        upper_next = up_sum[plvl_pkg::DATA_W-1:0];
        lower_next = lo_sum[plvl_pkg::DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        upper_reg <= upper_next;
        lower_reg <= lower_next;
    end

    assign done       = done_reg;
    assign upper_face = upper_reg;
    assign lower_face = lower_reg;

endmodule

// ===== design/plm_van_leer_reconstruction_top.sv =====
// done rises once an accepted start has passed the slope preparation stages, the divider stages and the face register.
// Throughput: one transfer per cycle; busy is held low.
// The divider is a 32-step restoring divider, one quotient bit per stage.
// Reset (rst_n low, asynchronous) clears all valid bits; no result in flight survives.
// The receiver cannot stall: each result is shown for exactly one cycle with done.
// ----------------------------------------------------------------------------
// plm_van_leer_reconstruction_top
// Piecewise linear reconstruction with the van Leer limiter, fully pipelined.
// ----------------------------------------------------------------------------
module plm_van_leer_reconstruction_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [plvl_pkg::DATA_W-1:0]  prev_value,
    input  logic signed [plvl_pkg::DATA_W-1:0]  centre_value,
    input  logic signed [plvl_pkg::DATA_W-1:0]  next_value,
    output logic                                done,
    output logic signed [plvl_pkg::DATA_W-1:0]  upper_face,
    output logic signed [plvl_pkg::DATA_W-1:0]  lower_face
);

    plvl_pkg::plvl_ctl_t  ctl [0:plvl_pkg::QUO_W];
    plvl_pkg::plvl_div_t  dat [0:plvl_pkg::QUO_W];

    assign busy = 1'b0;

    plvl_slope_prep u_prep
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start),
        .prev_value   (prev_value),
        .centre_value (centre_value),
        .next_value   (next_value),
        .ctl_out      (ctl[0]),
        .dat_out      (dat[0])
    );

    for (genvar k = 0; k < plvl_pkg::QUO_W; k++)
    begin : g_div
        plvl_div_stage u_div
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl[k]),
            .dat_in  (dat[k]),
            .ctl_out (ctl[k+1]),
            .dat_out (dat[k+1])
        );
    end

    plvl_face u_face
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (ctl[plvl_pkg::QUO_W]),
        .dat_in     (dat[plvl_pkg::QUO_W]),
        .done       (done),
        .upper_face (upper_face),
        .lower_face (lower_face)
    );

endmodule
